@@ src/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Holds the list depth, the index widths, the opcode and status codes,
// the transaction structs of both channels and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

    // List geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [1:0]         req_type;
        logic [8:0]         position;
        logic signed [31:0] word;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_word;
        logic [7:0]         found_position;
        logic [8:0]         list_length;
    } t_out_item;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WORK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ src/ale_ram.sv @@
// ----------------------------------------------------------------------------
// ale_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/array_list_engine.sv @@
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed 32-bit words
// Append, insert, remove and search on a list held in one RAM, with the
// shifts and the search walking the list one entry per cycle.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------
//  request | in        | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  result  | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One request is worked on at a time. Append and every rejected request go
// from the decide state straight to the emit state; insert, remove and
// search walk the affected entries through the single RAM read port one per
// cycle, a search stopping at its first hit. Insert at the end of the list
// and search on an empty list walk no entries. A stalled output holds the
// next result back. Reset clears the length and the control state; the RAM
// is not cleared, as no entry at or above the length is ever read. A new
// request is accepted while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine
    import ale_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    t_state                    r_state, n_state;
    t_in_item                  r_req, n_req;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [ADDR_W-1:0]         r_ptr, n_ptr;
    logic                      r_issue, n_issue;
    logic                      r_pend, n_pend;
    logic [ADDR_W-1:0]         r_paddr, n_paddr;
    logic [1:0]                r_status, n_status;
    logic [DATA_W-1:0]         r_removed, n_removed;
    logic [ADDR_W-1:0]         r_found, n_found;
    logic                      r_out_vld, n_out_vld;
    t_out_item                 r_out, n_out;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [DATA_W-1:0]         ram_rdata;
    logic [ADDR_W-1:0]         last_addr;
    logic [ADDR_W-1:0]         pos_addr;

    // List storage.
    ale_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign pos_addr = r_req.position[ADDR_W-1:0];

    // The walk stops at the insert position going down, or at the last
    // entry going up.
    assign last_addr = (r_req.req_type == OP_INSERT) ? pos_addr
                                                     : ADDR_W'(r_len - LEN_W'(1));

    // Next state, RAM write port and result capture.
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_len     = r_len;
        n_ptr     = r_ptr;
        n_issue   = r_issue;
        n_pend    = r_pend;
        n_paddr   = r_paddr;
        n_status  = r_status;
        n_removed = r_removed;
        n_found   = r_found;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_paddr;
        ram_wdata = ram_rdata;

        // A waiting result leaves when the consumer takes it.
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_item;
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_status  = STAT_OK;
                n_removed = '0;
                n_found   = '0;
                n_pend    = 1'b0;
                n_issue   = 1'b0;
                n_state   = ST_WORK;
                unique case (r_req.req_type)
                    OP_APPEND: begin
                        if (32'(r_len) >= DEPTH) begin
                            n_status = STAT_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_len[ADDR_W-1:0];
                            ram_wdata = r_req.word;
                            n_len     = r_len + LEN_W'(1);
                        end
                        n_state = ST_EMIT;
                    end
                    OP_INSERT: begin
                        if (32'(r_req.position) > 32'(r_len)) begin
                            n_status = STAT_BAD_INDEX;
                            n_state  = ST_EMIT;
                        end else if (32'(r_len) >= DEPTH) begin
                            n_status = STAT_FULL;
                            n_state  = ST_EMIT;
                        end else begin
                            n_issue = (32'(r_len) > 32'(r_req.position));
                            n_ptr   = ADDR_W'(r_len - LEN_W'(1));
                        end
                    end
                    OP_REMOVE: begin
                        if (32'(r_req.position) >= 32'(r_len)) begin
                            n_status = STAT_BAD_INDEX;
                            n_state  = ST_EMIT;
                        end else begin
                            n_issue = 1'b1;
                            n_ptr   = pos_addr;
                        end
                    end
                    OP_SEARCH: begin
                        n_issue = (r_len != '0);
                        n_ptr   = '0;
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end

            ST_WORK: begin
                // Read side: issue the next entry of the walk.
                if (r_issue) begin
                    n_pend  = 1'b1;
                    n_paddr = r_ptr;
                    if (r_ptr == last_addr) begin
                        n_issue = 1'b0;
                    end else if (r_req.req_type == OP_INSERT) begin
                        n_ptr = r_ptr - ADDR_W'(1);
                    end else begin
                        n_ptr = r_ptr + ADDR_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end

                // Data side: the entry read last cycle arrives now.
                if (r_pend) begin
                    unique case (r_req.req_type)
                        OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_paddr + ADDR_W'(1);
                        end
                        OP_REMOVE: begin
                            if (r_paddr == pos_addr) begin
                                n_removed = ram_rdata;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_paddr - ADDR_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (ram_rdata == r_req.word) begin
                                n_found  = r_paddr;
                                n_status = STAT_OK;
                                n_issue  = 1'b0;
                                n_pend   = 1'b0;
                                n_state  = ST_EMIT;
                            end
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end

                // Walk finished: close out the operation.
                if (!r_issue && !r_pend) begin
                    unique case (r_req.req_type)
                        OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_addr;
                            ram_wdata = r_req.word;
                            n_len     = r_len + LEN_W'(1);
                        end
                        OP_REMOVE: begin
                            n_len = r_len - LEN_W'(1);
                        end
                        OP_SEARCH: begin
                            n_status = STAT_NOT_FOUND;
                        end
                        default: begin
                            n_status = r_status;
                        end
                    endcase
                    n_state = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld                = 1'b1;
                    n_out.status             = r_status;
                    n_out.removed_word       = r_removed;
                    n_out.found_position     = 8'(r_found);
                    n_out.list_length        = 9'(r_len);
                    n_state                  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_issue   <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_ptr     <= n_ptr;
        r_paddr   <= n_paddr;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ src/ale_chk.sv @@
// ----------------------------------------------------------------------------
// ale_chk: port checker for the array list engine
// Watches both channels of the top level and flags results or handshake
// behavior that the list engine can never legally show.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_chk
    import ale_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // A stalled result transaction holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // The reported length never exceeds the list depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_item.list_length) <= DEPTH)
        else $error("list length above depth");

    // Failed requests return no removed word and no found position.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != STAT_OK
            |-> o_out_item.removed_word == '0 && o_out_item.found_position == '0)
        else $error("failed request carries data");

    // The engine works on one request at a time.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while busy");

    // No result appears the cycle after a request is taken.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind array_list_engine ale_chk u_ale_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
